FILE: src/rdfg_pkg.sv
// Shared types, register indexes and constant helpers for the reset declick fade gate.
// Depends on nothing; every other file in src imports this package.
`default_nettype none

package rdfg_pkg;

   // Channel count that the datapath is built for; active_channels clamps to it.
   localparam int unsigned CHANNELS = 2;

   // Fraction bits of a Q1.15 sample.
   localparam int unsigned SAMPLE_FRAC = 15;

   localparam logic [1:0]  ACTIVE_CHANNELS_RESET = 2'd2;
   localparam logic [14:0] GATE_THRESHOLD_RESET  = 15'd66;

   typedef enum logic {
      REG_ACTIVE_CHANNELS = 1'b0,
      REG_GATE_THRESHOLD  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      MODE_PASS  = 4'b0001,
      MODE_EDGE  = 4'b0010,
      MODE_MUTE  = 4'b0100,
      MODE_ONSET = 4'b1000
   } fade_mode_type;

   typedef struct packed {
      logic               req_type;
      logic signed [15:0] sample_left;
      logic signed [15:0] sample_right;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] out_left;
      logic signed [15:0] out_right;
   } rsp_payload_type;

   // Per-transfer events from the datapath to the fade controller.
   typedef struct packed {
      logic frame;
      logic restart;
      logic loud;
   } fade_event_type;

   function automatic bit fade_is_pow2(input int unsigned len);
      return (32'd1 << $clog2(len)) == len;
   endfunction

   // Fraction bits of the reciprocal gain. A power-of-two length is an exact shift;
   // otherwise enough bits are kept that a rounded reciprocal still floors exactly.
   function automatic int unsigned fade_shift(input int unsigned len);
      return fade_is_pow2(len) ? $clog2(len) : SAMPLE_FRAC + 2 * $clog2(len);
   endfunction

endpackage

`default_nettype wire

FILE: src/rdfg_scale.sv
// One fade multiplier: floor(value * factor / LEN) using a precomputed gain factor * ceil(2^S / LEN).
// Depends on rdfg_pkg for the shift helpers.
`default_nettype none

module rdfg_scale
   import rdfg_pkg::*;
#(
   parameter int unsigned LEN = 256,
   localparam int unsigned GW = fade_shift(LEN) + 1,
   localparam int unsigned FW = $clog2(LEN + 1)
) (
   input  logic signed [15:0]   value,
   input  logic        [GW-1:0] gain,
   input  logic        [FW-1:0] factor,
   output logic signed [15:0]   result
);

   localparam int unsigned SHIFT = fade_shift(LEN);
   localparam bit          POW2  = fade_is_pow2(LEN);
   localparam int unsigned PW    = GW + 17;

   logic        [GW-1:0] gain_sel;
   logic signed [PW-1:0] product;

   // The gain is built with the rounded-up reciprocal. Negative values need the
   // rounded-down one, which differs by exactly one per unit of factor.
   always_comb begin
      if (!POW2 && value[15]) begin
         gain_sel = gain - GW'(factor);
      end else begin
         gain_sel = gain;
      end
   end

   assign product = value * $signed({1'b0, gain_sel});
   assign result  = product[SHIFT +: 16];

endmodule

`default_nettype wire

FILE: src/rdfg_ctrl.sv
// Fade controller: edge and onset counters, their running gains and the signal gate.
// Depends on rdfg_pkg for the mode and event types and the shift helpers.
`default_nettype none

module rdfg_ctrl
   import rdfg_pkg::*;
#(
   parameter int unsigned EDGE_FADE_LEN  = 256,
   parameter int unsigned ONSET_FADE_LEN = 2048,
   localparam int unsigned EGW = fade_shift(EDGE_FADE_LEN) + 1,
   localparam int unsigned OGW = fade_shift(ONSET_FADE_LEN) + 1,
   localparam int unsigned EFW = $clog2(EDGE_FADE_LEN + 1),
   localparam int unsigned OFW = $clog2(ONSET_FADE_LEN + 1)
) (
   input  logic           clock,
   input  logic           reset,
   input  fade_event_type evt,
   output fade_mode_type  mode,
   output logic [EGW-1:0] edge_gain,
   output logic [EFW-1:0] edge_factor,
   output logic [OGW-1:0] onset_gain,
   output logic [OFW-1:0] onset_factor
);

   localparam int unsigned E_SHIFT = fade_shift(EDGE_FADE_LEN);
   localparam int unsigned O_SHIFT = fade_shift(ONSET_FADE_LEN);
   localparam longint unsigned E_MULT = fade_is_pow2(EDGE_FADE_LEN) ? 64'd1 :
      ((64'd1 << E_SHIFT) + EDGE_FADE_LEN - 1) / EDGE_FADE_LEN;
   localparam longint unsigned O_MULT = fade_is_pow2(ONSET_FADE_LEN) ? 64'd1 :
      ((64'd1 << O_SHIFT) + ONSET_FADE_LEN - 1) / ONSET_FADE_LEN;
   localparam longint unsigned E_START = (EDGE_FADE_LEN - 1) * E_MULT;

   logic [EFW-1:0] edge_cnt_ff, edge_cnt_in;
   logic [OFW-1:0] onset_cnt_ff, onset_cnt_in;
   logic           armed_ff, armed_in;
   logic [EGW-1:0] edge_gain_ff, edge_gain_in;
   logic [OGW-1:0] onset_gain_ff, onset_gain_in;
   logic           open_now;

   // The edge fade wins over the gate; the frame that opens the gate is already
   // the first step of the onset ramp.
   always_comb begin
      mode     = MODE_PASS;
      open_now = 1'b0;
      if (edge_cnt_ff != '0) begin
         mode = MODE_EDGE;
      end else if (armed_ff) begin
         if (evt.loud) begin
            mode     = MODE_ONSET;
            open_now = 1'b1;
         end else begin
            mode = MODE_MUTE;
         end
      end else if (onset_cnt_ff != '0) begin
         mode = MODE_ONSET;
      end
   end

   assign edge_gain    = edge_gain_ff;
   assign edge_factor  = edge_cnt_ff - EFW'(1);
   assign onset_gain   = open_now ? OGW'(O_MULT) : onset_gain_ff;
   assign onset_factor = open_now ? OFW'(1) : OFW'(ONSET_FADE_LEN - int'(onset_cnt_ff) + 1);

   always_comb begin
      edge_cnt_in   = edge_cnt_ff;
      onset_cnt_in  = onset_cnt_ff;
      armed_in      = armed_ff;
      edge_gain_in  = edge_gain_ff;
      onset_gain_in = onset_gain_ff;
      if (evt.restart) begin
         edge_cnt_in  = EFW'(EDGE_FADE_LEN);
         edge_gain_in = EGW'(E_START);
         onset_cnt_in = '0;
         armed_in     = 1'b1;
      end else if (evt.frame) begin
         case (mode)
            MODE_EDGE: begin
               edge_cnt_in  = edge_cnt_ff - EFW'(1);
               edge_gain_in = edge_gain_ff - EGW'(E_MULT);
            end
            MODE_ONSET: begin
               if (open_now) begin
                  armed_in      = 1'b0;
                  onset_cnt_in  = OFW'(ONSET_FADE_LEN - 1);
                  onset_gain_in = OGW'(2 * O_MULT);
               end else begin
                  onset_cnt_in  = onset_cnt_ff - OFW'(1);
                  onset_gain_in = onset_gain_ff + OGW'(O_MULT);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_cnt_ff  <= '0;
         onset_cnt_ff <= '0;
         armed_ff     <= 1'b0;
      end else begin
         edge_cnt_ff  <= edge_cnt_in;
         onset_cnt_ff <= onset_cnt_in;
         armed_ff     <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      edge_gain_ff  <= edge_gain_in;
      onset_gain_ff <= onset_gain_in;
   end

   // The gate can only be armed by a reset request, which also starts the edge fade.
   a_edge_implies_armed: assert property (@(posedge clock) disable iff (reset)
      (edge_cnt_ff != '0) |-> armed_ff)
      else $error("edge fade running without the gate armed");

   // The onset ramp is only loaded when the gate opens.
   a_armed_no_onset: assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> (onset_cnt_ff == '0))
      else $error("onset ramp running while the gate is armed");

endmodule

`default_nettype wire

FILE: src/reset_declick_fade_gate_top.sv
// Reset declick fade gate: one stereo Q1.15 frame in, one conditioned frame out per cycle.
// After a reset request the last outputs fade to zero over EDGE_FADE_LEN frames, the output
// then stays muted until the input peak exceeds gate_threshold, and an onset ramp of
// ONSET_FADE_LEN frames brings the signal back in. Each frame is worked out in the cycle
// it is transferred and its result is held in the output register, so one item is taken
// every cycle unless the output stalls; the path is set by one 16-bit by gain-width
// multiply per channel. A reset request is transferred like a frame but yields no result.
// Depends on rdfg_pkg, rdfg_ctrl and rdfg_scale.
`default_nettype none

module reset_declick_fade_gate_top
   import rdfg_pkg::*;
#(
   parameter int unsigned EDGE_FADE_LEN  = 256,
   parameter int unsigned ONSET_FADE_LEN = 2048
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data,
   input  logic            csr_we,
   input  csr_index_type   csr_addr,
   input  logic [14:0]     csr_wdata
);

   localparam int unsigned EGW = fade_shift(EDGE_FADE_LEN) + 1;
   localparam int unsigned OGW = fade_shift(ONSET_FADE_LEN) + 1;
   localparam int unsigned EFW = $clog2(EDGE_FADE_LEN + 1);
   localparam int unsigned OFW = $clog2(ONSET_FADE_LEN + 1);

   logic [1:0]         active_ch_ff;
   logic [14:0]        threshold_ff;
   logic signed [15:0] last_left_ff, last_right_ff;
   logic signed [15:0] start_left_ff, start_right_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   logic               fire, frame_fire, reset_fire, two_ch;
   logic signed [16:0] wide_left, wide_right;
   logic        [16:0] abs_left, abs_right;
   fade_event_type     evt;
   fade_mode_type      mode;
   logic [EGW-1:0]     edge_gain;
   logic [EFW-1:0]     edge_factor;
   logic [OGW-1:0]     onset_gain;
   logic [OFW-1:0]     onset_factor;
   logic signed [15:0] edge_left, edge_right, onset_left, onset_right;
   logic signed [15:0] y_left, y_right;

   // The output register parts the two sides: a new frame is taken whenever no result is
   // held or the held result leaves in the same cycle.
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign fire       = req_valid && req_ready;
   assign frame_fire = fire && !req_data.req_type;
   assign reset_fire = fire && req_data.req_type;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   // A channel count of zero acts as one; anything above the build width is clamped.
   assign two_ch = (CHANNELS > 1) && (active_ch_ff >= 2'd2);

   assign wide_left  = {req_data.sample_left[15], req_data.sample_left};
   assign wide_right = {req_data.sample_right[15], req_data.sample_right};
   assign abs_left   = wide_left[16] ? 17'(-wide_left) : 17'(wide_left);
   assign abs_right  = wide_right[16] ? 17'(-wide_right) : 17'(wide_right);

   assign evt.frame   = frame_fire;
   assign evt.restart = reset_fire;
   assign evt.loud    = (abs_left > {2'b00, threshold_ff})
                     || (two_ch && (abs_right > {2'b00, threshold_ff}));

   rdfg_ctrl #(
      .EDGE_FADE_LEN  (EDGE_FADE_LEN),
      .ONSET_FADE_LEN (ONSET_FADE_LEN)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .evt          (evt),
      .mode         (mode),
      .edge_gain    (edge_gain),
      .edge_factor  (edge_factor),
      .onset_gain   (onset_gain),
      .onset_factor (onset_factor)
   );

   rdfg_scale #(.LEN(EDGE_FADE_LEN)) u_edge_left (
      .value  (start_left_ff),
      .gain   (edge_gain),
      .factor (edge_factor),
      .result (edge_left)
   );

   rdfg_scale #(.LEN(EDGE_FADE_LEN)) u_edge_right (
      .value  (start_right_ff),
      .gain   (edge_gain),
      .factor (edge_factor),
      .result (edge_right)
   );

   rdfg_scale #(.LEN(ONSET_FADE_LEN)) u_onset_left (
      .value  (req_data.sample_left),
      .gain   (onset_gain),
      .factor (onset_factor),
      .result (onset_left)
   );

   rdfg_scale #(.LEN(ONSET_FADE_LEN)) u_onset_right (
      .value  (req_data.sample_right),
      .gain   (onset_gain),
      .factor (onset_factor),
      .result (onset_right)
   );

   always_comb begin
      case (mode)
         MODE_EDGE: begin
            y_left  = edge_left;
            y_right = edge_right;
         end
         MODE_MUTE: begin
            y_left  = '0;
            y_right = '0;
         end
         MODE_ONSET: begin
            y_left  = onset_left;
            y_right = onset_right;
         end
         default: begin
            y_left  = req_data.sample_left;
            y_right = req_data.sample_right;
         end
      endcase
      rsp_data_in.out_left  = y_left;
      rsp_data_in.out_right = two_ch ? y_right : 16'sd0;
   end

   always_comb begin
      if (frame_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         active_ch_ff   <= ACTIVE_CHANNELS_RESET;
         threshold_ff   <= GATE_THRESHOLD_RESET;
         last_left_ff   <= '0;
         last_right_ff  <= '0;
         start_left_ff  <= '0;
         start_right_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_addr)
               REG_ACTIVE_CHANNELS: active_ch_ff <= csr_wdata[1:0];
               REG_GATE_THRESHOLD:  threshold_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (reset_fire) begin
            start_left_ff  <= last_left_ff;
            start_right_ff <= last_right_ff;
         end
         if (frame_fire) begin
            last_left_ff <= y_left;
            if (two_ch) begin
               last_right_ff <= y_right;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (frame_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A reset request must never show up as a result.
   a_restart_silent: assert property (@(posedge clock) disable iff (reset)
      (reset_fire && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("reset request produced a result");

   // While the gate is shut both channels carry silence.
   a_mute_zero: assert property (@(posedge clock) disable iff (reset)
      (frame_fire && mode == MODE_MUTE) |=>
         (rsp_data_ff.out_left == 16'sd0 && rsp_data_ff.out_right == 16'sd0))
      else $error("muted frame is not silent");

   // An unused right channel keeps its last output.
   a_unused_right_held: assert property (@(posedge clock) disable iff (reset)
      (frame_fire && !two_ch) |=> $stable(last_right_ff))
      else $error("unused channel level changed");

endmodule

`default_nettype wire
